[rtl/acudm_pkg.sv]
// Package for the channel up/down mixer: sample, frame and accumulator types,
// fixed-point gain constants and the configuration register layout.
// No dependencies.
package acudm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int NCH         = 6;
	localparam int FRAC_BITS   = 15;
	localparam int SUM_W       = SAMPLE_BITS + 2;
	localparam int GAIN_W      = FRAC_BITS + 2;
	localparam int ACC_W       = SUM_W + GAIN_W;
	localparam int CH_W        = 3;
	localparam int IDX_W       = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t                       frame_t [NCH];
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef acc_t                          acc_frame_t [NCH];

	// sqrt(0.5) in Q.15, with a zero sign bit
	localparam logic signed [GAIN_W-1:0] GAIN_ROOT_HALF = GAIN_W'(23170);
	localparam acc_t                     ROUND_HALF     = acc_t'(1) <<< (FRAC_BITS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_IN_CH    = 2'd0,
		REG_OUT_CH   = 2'd1,
		REG_SPK_MODE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] in_ch;
		logic [CH_W-1:0] out_ch;
		logic            spk;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{in_ch: 3'd2, out_ch: 3'd2, spk: 1'b1};

endpackage

[rtl/audio_channel_up_down_mixer_unit.sv]
// Top level of the channel up/down mixer: config registers, input frame
// register, mix and round lanes, result register. Uses acudm_pkg,
// acudm_mix and acudm_round.
//
//   channel | handshake             | word
//   --------+-----------------------+----------------------------------
//   input   | start / busy          | sample_in_0 .. sample_in_5
//   result  | done (strobe)         | sample_out_0 .. sample_out_5
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One frame per cycle; each frame passes the input register, then mix/round
// into the result register.
// busy and cfg_ready are always low and high respectively.
// arst_n clears the valid pipeline and loads the register defaults.
// done is a one-cycle strobe; the receiver cannot stall.
module audio_channel_up_down_mixer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  acudm_pkg::sample_t         sample_in_0,
	input  acudm_pkg::sample_t         sample_in_1,
	input  acudm_pkg::sample_t         sample_in_2,
	input  acudm_pkg::sample_t         sample_in_3,
	input  acudm_pkg::sample_t         sample_in_4,
	input  acudm_pkg::sample_t         sample_in_5,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [acudm_pkg::IDX_W-1:0] cfg_index,
	input  logic [acudm_pkg::CH_W-1:0]  cfg_data,
	output logic                       done,
	output acudm_pkg::sample_t         sample_out_0,
	output acudm_pkg::sample_t         sample_out_1,
	output acudm_pkg::sample_t         sample_out_2,
	output acudm_pkg::sample_t         sample_out_3,
	output acudm_pkg::sample_t         sample_out_4,
	output acudm_pkg::sample_t         sample_out_5
);
	import acudm_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	frame_t     x_s1;
	logic       done_s2;
	frame_t     y_s2;
	acc_frame_t acc;
	frame_t     y;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_CH:    cfg_q.in_ch  <= cfg_data;
				REG_OUT_CH:   cfg_q.out_ch <= cfg_data;
				REG_SPK_MODE: cfg_q.spk    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			x_s1[0] <= sample_in_0;
			x_s1[1] <= sample_in_1;
			x_s1[2] <= sample_in_2;
			x_s1[3] <= sample_in_3;
			x_s1[4] <= sample_in_4;
			x_s1[5] <= sample_in_5;
		end
		if (valid_s1)
			y_s2 <= y;
	end

	acudm_mix u_mix (
		.cfg (cfg_q),
		.x   (x_s1),
		.acc (acc)
	);

	for (genvar k = 0; k < NCH; k++) begin : g_lane
		acudm_round u_round (
			.acc (acc[k]),
			.y   (y[k])
		);
	end

	assign done         = done_s2;
	assign sample_out_0 = y_s2[0];
	assign sample_out_1 = y_s2[1];
	assign sample_out_2 = y_s2[2];
	assign sample_out_3 = y_s2[3];
	assign sample_out_4 = y_s2[4];
	assign sample_out_5 = y_s2[5];

	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 == $past(valid_s1))
		else $error("done strobe out of step with stage 1");

	a_start_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted word gave no result two cycles later");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s2 && $past(cfg_q.out_ch) == 3'd0) |->
		(y_s2[0] == '0 && y_s2[1] == '0 && y_s2[2] == '0 &&
		 y_s2[3] == '0 && y_s2[4] == '0 && y_s2[5] == '0))
		else $error("nonzero output with zero output channels");

	a_mono_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s2 && $past(cfg_q.out_ch) == 3'd1) |->
		(y_s2[1] == '0 && y_s2[2] == '0 && y_s2[3] == '0 &&
		 y_s2[4] == '0 && y_s2[5] == '0))
		else $error("unused slot nonzero on mono output");

endmodule

[rtl/acudm_mix.sv]
// Channel routing and gain sums for one frame: decodes the speaker layout
// conversion and forms each lane's Q.15 accumulator. Uses acudm_pkg.
module acudm_mix (
	input  acudm_pkg::cfg_t       cfg,
	input  acudm_pkg::frame_t     x,
	output acudm_pkg::acc_frame_t acc
);
	import acudm_pkg::*;

	typedef enum logic [3:0] {
		MIX_COPY,
		MIX_1_24,
		MIX_1_6,
		MIX_2_1,
		MIX_2_46,
		MIX_4_1,
		MIX_4_2,
		MIX_4_6,
		MIX_6_1,
		MIX_6_2,
		MIX_6_4
	} mix_t;

	function automatic logic layout_ok(input logic [CH_W-1:0] n);
		return (n == 3'd1) || (n == 3'd2) || (n == 3'd4) || (n == 3'd6);
	endfunction

	mix_t                          mode;
	logic                          spk;
	logic [CH_W-1:0]               n_copy;
	sum_t                          a [NCH];
	sum_t                          h [NCH];
	sum_t                          q0;
	sum_t                          r0;
	sum_t                          r1;
	logic signed [ACC_W-1:0]       prod0;
	logic signed [ACC_W-1:0]       prod1;

	assign spk = cfg.spk && layout_ok(cfg.in_ch) && layout_ok(cfg.out_ch)
		&& (cfg.in_ch != cfg.out_ch);

	always_comb begin
		mode = MIX_COPY;
		if (spk) begin
			unique case ({cfg.in_ch, cfg.out_ch})
				{3'd1, 3'd2}, {3'd1, 3'd4}: mode = MIX_1_24;
				{3'd1, 3'd6}:               mode = MIX_1_6;
				{3'd2, 3'd1}:               mode = MIX_2_1;
				{3'd2, 3'd4}, {3'd2, 3'd6}: mode = MIX_2_46;
				{3'd4, 3'd1}:               mode = MIX_4_1;
				{3'd4, 3'd2}:               mode = MIX_4_2;
				{3'd4, 3'd6}:               mode = MIX_4_6;
				{3'd6, 3'd1}:               mode = MIX_6_1;
				{3'd6, 3'd2}:               mode = MIX_6_2;
				{3'd6, 3'd4}:               mode = MIX_6_4;
				default:                    mode = MIX_COPY;
			endcase
		end
	end

	// discrete copy count, a count of 7 means all six slots
	always_comb begin
		n_copy = (cfg.in_ch < cfg.out_ch) ? cfg.in_ch : cfg.out_ch;
		if (n_copy == 3'd7)
			n_copy = 3'd6;
	end

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			a[k] = '0;
			h[k] = '0;
		end
		q0 = '0;
		r0 = '0;
		r1 = '0;
		unique case (mode)
			MIX_COPY: begin
				for (int k = 0; k < NCH; k++)
					if (CH_W'(k) < n_copy)
						a[k] = SUM_W'(x[k]);
			end
			MIX_1_24: begin
				a[0] = SUM_W'(x[0]);
				a[1] = SUM_W'(x[0]);
			end
			MIX_1_6: a[2] = SUM_W'(x[0]);
			MIX_2_1: h[0] = SUM_W'(x[0]) + SUM_W'(x[1]);
			MIX_2_46: begin
				a[0] = SUM_W'(x[0]);
				a[1] = SUM_W'(x[1]);
			end
			MIX_4_1: q0 = SUM_W'(x[0]) + SUM_W'(x[1]) + SUM_W'(x[2]) + SUM_W'(x[3]);
			MIX_4_2: begin
				h[0] = SUM_W'(x[0]) + SUM_W'(x[2]);
				h[1] = SUM_W'(x[1]) + SUM_W'(x[3]);
			end
			MIX_4_6: begin
				a[0] = SUM_W'(x[0]);
				a[1] = SUM_W'(x[1]);
				a[4] = SUM_W'(x[2]);
				a[5] = SUM_W'(x[3]);
			end
			MIX_6_1: begin
				r0   = SUM_W'(x[0]) + SUM_W'(x[1]);
				a[0] = SUM_W'(x[2]);
				h[0] = SUM_W'(x[4]) + SUM_W'(x[5]);
			end
			MIX_6_2: begin
				a[0] = SUM_W'(x[0]);
				r0   = SUM_W'(x[2]) + SUM_W'(x[4]);
				a[1] = SUM_W'(x[1]);
				r1   = SUM_W'(x[2]) + SUM_W'(x[5]);
			end
			MIX_6_4: begin
				a[0] = SUM_W'(x[0]);
				r0   = SUM_W'(x[2]);
				a[1] = SUM_W'(x[1]);
				r1   = SUM_W'(x[2]);
				a[2] = SUM_W'(x[4]);
				a[3] = SUM_W'(x[5]);
			end
			default: ;
		endcase
	end

	assign prod0 = r0 * GAIN_ROOT_HALF;
	assign prod1 = r1 * GAIN_ROOT_HALF;

	always_comb begin
		for (int k = 0; k < NCH; k++)
			acc[k] = (ACC_W'(a[k]) <<< FRAC_BITS) + (ACC_W'(h[k]) <<< (FRAC_BITS - 1));
		acc[0] = acc[0] + (ACC_W'(q0) <<< (FRAC_BITS - 2)) + prod0;
		acc[1] = acc[1] + prod1;
	end

endmodule

[rtl/acudm_round.sv]
// Round-to-nearest (ties up) and saturation of one Q.15 accumulator lane
// to a sample. Uses acudm_pkg.
module acudm_round (
	input  acudm_pkg::acc_t    acc,
	output acudm_pkg::sample_t y
);
	import acudm_pkg::*;

	localparam acc_t SAT_HI = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam acc_t SAT_LO = ~SAT_HI;

	acc_t t;
	acc_t q;

	assign t = acc + ROUND_HALF;
	assign q = t >>> FRAC_BITS;

	always_comb begin
		priority if (q > SAT_HI)
			y = SAT_HI[SAMPLE_BITS-1:0];
		else if (q < SAT_LO)
			y = SAT_LO[SAMPLE_BITS-1:0];
		else
			y = q[SAMPLE_BITS-1:0];
	end

endmodule
